FILE: hw/rtl/fwlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwlr_pkg;

  localparam int BLK_W   = 14;
  localparam int BASE_W  = 17;
  localparam int ADDR_W  = 21;
  localparam int CNT_W   = 13;
  localparam int ENTRY_W = 16;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [2:0] CMD_RD_MAP   = 3'd0;
  localparam logic [2:0] CMD_RD_DATA  = 3'd1;
  localparam logic [2:0] CMD_WR_ENTRY = 3'd2;
  localparam logic [2:0] CMD_ERASE    = 3'd3;
  localparam logic [2:0] CMD_WR_DATA  = 3'd4;
  localparam logic [2:0] CMD_WR_BLANK = 3'd5;

  localparam logic [ENTRY_W-1:0] FREE_ENTRY = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       operation;
    logic [BLK_W-1:0] logical_block;
    logic [4:0]       fill_index;
    logic [15:0]      fill_value;
  } item_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [ADDR_W-1:0]  flash_address;
    logic [CNT_W-1:0]   byte_count;
    logic [ENTRY_W-1:0] entry_value;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [BASE_W-1:0] block;
  } cmd_ent_t;

endpackage

`default_nettype wire

FILE: hw/rtl/flash_wear_level_remapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Flash wear-leveling block remapper.
// Channel item (item_valid/item_ready/item) carries read requests, write
// requests and map word fills; channel cmd (cmd_valid/cmd_ready/cmd) carries
// the flash commands, one transaction each, with last set on the final
// command caused by an item. Each item produces zero to four commands.
// A request for a group whose map is not loaded passes DIVQ and ROUTE, then
// EMIT loads its map read into the output register and the input is freed;
// fills are written in IDLE. A request against a loaded map scans the
// PAGE_BLOCKS-1 slot entries of the map memory one per cycle over its single
// read port, as does the last fill, before SCAN_END, DECIDE and EMIT; each
// command waits in EMIT for the output register. A write that finds no free
// slot adds a CLEAR pass that rewrites every entry of the map memory.
// item_ready is high only while no item is in work. Commands leave through
// an output register; when the receiver stalls, the command holds and the
// next one waits. Reset clears the loaded and held flags and the map base;
// map memory contents are undefined until filled.
module flash_wear_level_remapper_top #(
  parameter int BLOCK_BYTES  = 128,
  parameter int PAGE_BLOCKS  = 32,
  parameter int GROUP_BLOCKS = 2048,
  parameter int FLASH_BLOCKS = 16384
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire fwlr_pkg::item_t item,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output fwlr_pkg::cmd_t       cmd
);

  localparam int SW      = $clog2(PAGE_BLOCKS);
  localparam int BW      = fwlr_pkg::BASE_W;
  localparam int Q_DEPTH = ((1 << fwlr_pkg::BLK_W) - 1) / GROUP_BLOCKS + 1;
  localparam int QW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_ENT   = 1 << QW;
  localparam int DIV_S   = fwlr_pkg::BLK_W + $clog2(GROUP_BLOCKS);
  localparam logic [15:0] DIV_M =
    16'(((64'd1 << DIV_S) + 64'(GROUP_BLOCKS) - 64'd1) / 64'(GROUP_BLOCKS));
  localparam logic [fwlr_pkg::CNT_W-1:0] BLK_CNT = fwlr_pkg::CNT_W'(BLOCK_BYTES);
  localparam logic [fwlr_pkg::CNT_W-1:0] ERASE_CNT =
    fwlr_pkg::CNT_W'(PAGE_BLOCKS * BLOCK_BYTES);
  localparam logic [SW-1:0] LAST_SLOT = SW'(PAGE_BLOCKS - 1);

  typedef enum logic [7:0] {
    IDLE     = 8'b0000_0001,
    DIVQ     = 8'b0000_0010,
    ROUTE    = 8'b0000_0100,
    SCAN     = 8'b0000_1000,
    SCAN_END = 8'b0001_0000,
    DECIDE   = 8'b0010_0000,
    CLEAR    = 8'b0100_0000,
    EMIT     = 8'b1000_0000
  } state_t;

  state_t state;

  logic [15:0] slot_mem [PAGE_BLOCKS];
  logic        mem_we;
  logic [SW-1:0] mem_wa;
  logic [15:0] mem_wd;
  logic [15:0] rd_data;
  logic        rd_vld;
  logic [SW-1:0] rd_idx;
  logic [SW-1:0] chk_idx;
  logic [SW-1:0] clr_idx;

  logic        map_loaded;
  logic [BW-1:0] map_base;
  logic [SW-1:0] map_mod;
  logic        held_valid;
  logic        held_write;
  logic [fwlr_pkg::BLK_W-1:0] held_block;
  logic [QW-1:0] q_reg;
  logic        found;
  logic [SW-1:0] slot;

  fwlr_pkg::cmd_ent_t list [4];
  fwlr_pkg::cmd_ent_t list_new [4];
  logic [2:0]  list_n;
  logic [2:0]  cnt;
  logic [1:0]  emit_idx;

  logic [BW-1:0] base_tab [Q_ENT];
  logic [SW-1:0] mod_tab [Q_ENT];

  for (genvar g = 0; g < Q_ENT; g++) begin : g_tab
    assign base_tab[g] = BW'((g + 1) * GROUP_BLOCKS - PAGE_BLOCKS);
    assign mod_tab[g]  = SW'(((g + 1) * GROUP_BLOCKS) % PAGE_BLOCKS);
  end

  logic        item_fire;
  logic        is_req;
  logic        fill_ok;
  logic [29:0] div_prod;
  logic        hit;
  logic [SW-1:0] slot_w;
  logic [BW-1:0] slot_blk;
  logic        erase_d;
  logic        out_free;
  fwlr_pkg::cmd_ent_t ent;
  logic [29:0] addr_prod;

  assign item_ready = (state == IDLE);
  assign item_fire  = item_valid && item_ready;
  assign is_req     = (item.operation == fwlr_pkg::OP_READ ||
                       item.operation == fwlr_pkg::OP_WRITE) &&
                      (32'(item.logical_block) < FLASH_BLOCKS);
  assign fill_ok    = (item.operation == fwlr_pkg::OP_FILL) && held_valid &&
                      (32'(item.fill_index) < PAGE_BLOCKS);
  assign div_prod   = 30'(held_block) * 30'(DIV_M);
  assign hit        = map_loaded && !held_valid && (base_tab[q_reg] == map_base);
  assign slot_w     = found ? slot : SW'(1);
  assign slot_blk   = map_base + BW'(slot_w);
  assign erase_d    = ({1'b0, map_mod} + {1'b0, slot_w}) == (SW + 1)'(PAGE_BLOCKS);
  assign out_free   = !cmd_valid || cmd_ready;
  assign ent        = list[emit_idx];
  assign addr_prod  = 30'(ent.block) * 30'(BLOCK_BYTES);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      list_new[k] = '{command: fwlr_pkg::CMD_RD_DATA, block: '0};
    end
    cnt = 3'd0;
    if (!held_write) begin
      list_new[0] = '{command: fwlr_pkg::CMD_RD_DATA,
                      block: found ? slot_blk : BW'(held_block)};
      cnt = 3'd1;
    end else begin
      if (!found && (map_mod == '0)) begin
        list_new[cnt[1:0]] = '{command: fwlr_pkg::CMD_ERASE, block: map_base};
        cnt = cnt + 3'd1;
      end
      if (!found) begin
        list_new[cnt[1:0]] = '{command: fwlr_pkg::CMD_WR_BLANK, block: map_base};
        cnt = cnt + 3'd1;
      end
      list_new[cnt[1:0]] = '{command: fwlr_pkg::CMD_WR_ENTRY, block: map_base};
      cnt = cnt + 3'd1;
      if (erase_d) begin
        list_new[cnt[1:0]] = '{command: fwlr_pkg::CMD_ERASE, block: slot_blk};
        cnt = cnt + 3'd1;
      end
      list_new[cnt[1:0]] = '{command: fwlr_pkg::CMD_WR_DATA, block: slot_blk};
      cnt = cnt + 3'd1;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = fwlr_pkg::FREE_ENTRY;
    unique case (state)
      IDLE: begin
        mem_we = item_fire && fill_ok;
        mem_wa = SW'(item.fill_index);
        mem_wd = item.fill_value;
      end
      DECIDE: begin
        mem_we = held_write && found;
        mem_wa = slot;
        mem_wd = 16'(held_block);
      end
      CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = (clr_idx == SW'(1)) ? 16'(held_block) : fwlr_pkg::FREE_ENTRY;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_data <= slot_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cmd_valid  <= 1'b0;
      held_valid <= 1'b0;
      held_write <= 1'b0;
      held_block <= '0;
      map_loaded <= 1'b0;
      map_base   <= '0;
      map_mod    <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (state == EMIT && out_free) begin
        cmd_valid <= 1'b1;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
      if (rd_vld) begin
        if (held_write) begin
          if (rd_data == fwlr_pkg::FREE_ENTRY && !found) begin
            found <= 1'b1;
            slot  <= chk_idx;
          end
        end else if (rd_data == 16'(held_block)) begin
          found <= 1'b1;
          slot  <= chk_idx;
        end
      end
      unique case (state)
        IDLE: begin
          rd_vld <= 1'b0;
          if (item_fire) begin
            if (fill_ok && (32'(item.fill_index) == PAGE_BLOCKS - 1)) begin
              held_valid <= 1'b0;
              map_loaded <= 1'b1;
              found      <= 1'b0;
              rd_idx     <= SW'(1);
              state      <= SCAN;
            end else if (is_req) begin
              held_block <= item.logical_block;
              held_write <= (item.operation == fwlr_pkg::OP_WRITE);
              state      <= DIVQ;
            end
          end
        end
        DIVQ: begin
          q_reg <= QW'(div_prod >> DIV_S);
          state <= ROUTE;
        end
        ROUTE: begin
          emit_idx <= '0;
          if (hit) begin
            found  <= 1'b0;
            rd_idx <= SW'(1);
            state  <= SCAN;
          end else begin
            map_base   <= base_tab[q_reg];
            map_mod    <= mod_tab[q_reg];
            map_loaded <= 1'b0;
            held_valid <= 1'b1;
            list[0]    <= '{command: fwlr_pkg::CMD_RD_MAP, block: base_tab[q_reg]};
            list_n     <= 3'd1;
            state      <= EMIT;
          end
        end
        SCAN: begin
          rd_vld  <= 1'b1;
          chk_idx <= rd_idx;
          if (rd_idx == LAST_SLOT) begin
            state <= SCAN_END;
          end else begin
            rd_idx <= rd_idx + SW'(1);
          end
        end
        SCAN_END: begin
          rd_vld <= 1'b0;
          state  <= DECIDE;
        end
        DECIDE: begin
          list     <= list_new;
          list_n   <= cnt;
          emit_idx <= '0;
          slot     <= slot_w;
          clr_idx  <= '0;
          state    <= (held_write && !found) ? CLEAR : EMIT;
        end
        CLEAR: begin
          if (clr_idx == LAST_SLOT) begin
            state <= EMIT;
          end else begin
            clr_idx <= clr_idx + SW'(1);
          end
        end
        EMIT: begin
          if (out_free) begin
            emit_idx <= emit_idx + 2'd1;
            if ({1'b0, emit_idx} == list_n - 3'd1) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == EMIT && out_free) begin
      cmd.command     <= ent.command;
      cmd.entry_value <= (ent.command == fwlr_pkg::CMD_WR_ENTRY) ? 16'(held_block) : '0;
      cmd.last        <= ({1'b0, emit_idx} == list_n - 3'd1);
      case (ent.command)
        fwlr_pkg::CMD_WR_ENTRY: begin
          cmd.flash_address <= fwlr_pkg::ADDR_W'(addr_prod) +
                               fwlr_pkg::ADDR_W'({slot, 1'b0});
          cmd.byte_count    <= fwlr_pkg::CNT_W'(2);
        end
        fwlr_pkg::CMD_ERASE: begin
          cmd.flash_address <= fwlr_pkg::ADDR_W'(addr_prod);
          cmd.byte_count    <= ERASE_CNT;
        end
        default: begin
          cmd.flash_address <= fwlr_pkg::ADDR_W'(addr_prod);
          cmd.byte_count    <= BLK_CNT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/flash_wear_level_remapper_top_tb.sv
`timescale 1ns / 1ps

module flash_wear_level_remapper_top_tb;

  localparam int BLOCK_BYTES  = 128;
  localparam int PAGE_BLOCKS  = 32;
  localparam int GROUP_BLOCKS = 2048;
  localparam int FLASH_BLOCKS = 16384;
  localparam int GROUPS       = FLASH_BLOCKS / GROUP_BLOCKS;
  localparam int ITEM_TARGET  = 470;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE       = 120;
  localparam int ITEM_W       = $bits(fwlr_pkg::item_t);

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum int {FILL_SPARSE, FILL_PACKED, FILL_MIXED} fill_mode_t;

  class remap_scoreboard;
    logic [fwlr_pkg::ENTRY_W-1:0] slot_tbl[PAGE_BLOCKS];
    logic [PAGE_BLOCKS-1:0]       loaded_entries;
    int unsigned                  page_base;
    bit                           map_ready;
    bit                           hold_valid;
    bit                           hold_write;
    logic [fwlr_pkg::BLK_W-1:0]   hold_block;
    fwlr_pkg::cmd_t               cmd_q[$];
    int                           n_fail;

    function new();
      loaded_entries = '0;
      page_base      = 0;
      map_ready      = 1'b0;
      hold_valid     = 1'b0;
      hold_write     = 1'b0;
      hold_block     = '0;
      n_fail         = 0;
    endfunction

    function void push_cmd(logic [2:0] code, int unsigned addr, int unsigned count,
                           int unsigned value);
      fwlr_pkg::cmd_t c;
      c.command       = code;
      c.flash_address = fwlr_pkg::ADDR_W'(addr);
      c.byte_count    = fwlr_pkg::CNT_W'(count);
      c.entry_value   = fwlr_pkg::ENTRY_W'(value);
      c.last          = 1'b0;
      cmd_q.push_back(c);
    endfunction

    function void program_block(int unsigned blk, logic [2:0] code);
      if (blk % PAGE_BLOCKS == 0) begin
        push_cmd(fwlr_pkg::CMD_ERASE, blk * BLOCK_BYTES, PAGE_BLOCKS * BLOCK_BYTES, 0);
      end
      push_cmd(code, blk * BLOCK_BYTES, BLOCK_BYTES, 0);
    endfunction

    function void serve_request(bit is_write, logic [fwlr_pkg::BLK_W-1:0] blk);
      int unsigned target;
      int unsigned slot;
      if (!is_write) begin
        target = blk;
        for (int i = 1; i < PAGE_BLOCKS; i++) begin
          if (slot_tbl[i] == fwlr_pkg::ENTRY_W'(blk)) target = page_base + i;
        end
        push_cmd(fwlr_pkg::CMD_RD_DATA, target * BLOCK_BYTES, BLOCK_BYTES, 0);
      end else begin
        slot = 0;
        for (int i = 1; i < PAGE_BLOCKS; i++) begin
          if (slot == 0 && slot_tbl[i] == fwlr_pkg::FREE_ENTRY) slot = i;
        end
        if (slot == 0) begin
          foreach (slot_tbl[k]) slot_tbl[k] = fwlr_pkg::FREE_ENTRY;
          loaded_entries = '1;
          program_block(page_base, fwlr_pkg::CMD_WR_BLANK);
          slot = 1;
        end
        slot_tbl[slot] = fwlr_pkg::ENTRY_W'(blk);
        push_cmd(fwlr_pkg::CMD_WR_ENTRY, page_base * BLOCK_BYTES + 2 * slot, 2, blk);
        program_block(page_base + slot, fwlr_pkg::CMD_WR_DATA);
      end
    endfunction

    // Returns 0 for a transaction the block ignores.
    function bit note_item(fwlr_pkg::item_t it);
      int unsigned    base;
      int             n_prior;
      fwlr_pkg::cmd_t tail;
      n_prior = cmd_q.size();
      if (it.operation == fwlr_pkg::OP_FILL) begin
        if (!hold_valid) return 1'b0;
        slot_tbl[it.fill_index]       = it.fill_value;
        loaded_entries[it.fill_index] = 1'b1;
        if (it.fill_index == 5'(PAGE_BLOCKS - 1)) begin
          hold_valid = 1'b0;
          map_ready  = 1'b1;
          serve_request(hold_write, hold_block);
        end
      end else if (it.operation == OP_NONE) begin
        return 1'b0;
      end else begin
        base = (int'(it.logical_block) / GROUP_BLOCKS + 1) * GROUP_BLOCKS - PAGE_BLOCKS;
        if (map_ready && !hold_valid && base == page_base) begin
          serve_request(it.operation == fwlr_pkg::OP_WRITE, it.logical_block);
        end else begin
          page_base  = base;
          map_ready  = 1'b0;
          hold_valid = 1'b1;
          hold_write = (it.operation == fwlr_pkg::OP_WRITE);
          hold_block = it.logical_block;
          push_cmd(fwlr_pkg::CMD_RD_MAP, base * BLOCK_BYTES, BLOCK_BYTES, 0);
        end
      end
      if (cmd_q.size() > n_prior) begin
        tail      = cmd_q.pop_back();
        tail.last = 1'b1;
        cmd_q.push_back(tail);
      end
      return 1'b1;
    endfunction

    function string show(fwlr_pkg::cmd_t c);
      return $sformatf("cmd=%0d addr=0x%06h count=%0d entry=0x%04h last=%0b",
                       c.command, c.flash_address, c.byte_count, c.entry_value, c.last);
    endfunction

    function void flag(string msg);
      n_fail++;
      if (n_fail <= MAX_REPORTS) $display("%0t %s", $time, msg);
    endfunction

    function void check_cmd(fwlr_pkg::cmd_t got);
      fwlr_pkg::cmd_t want;
      if (cmd_q.size() == 0) begin
        flag($sformatf("unexpected transaction: %s", show(got)));
        return;
      end
      want = cmd_q.pop_front();
      if (got.command !== want.command || got.flash_address !== want.flash_address ||
          got.byte_count !== want.byte_count || got.entry_value !== want.entry_value ||
          got.last !== want.last) begin
        flag($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       item_valid;
  logic                       item_ready;
  fwlr_pkg::item_t            item;
  logic                       cmd_valid;
  logic                       cmd_ready;
  fwlr_pkg::cmd_t             cmd;
  int                         send_idle;
  int                         recv_idle;
  int                         useful_items;
  int                         quiet_cycles;
  logic [fwlr_pkg::BLK_W-1:0] hot_blocks[4];
  remap_scoreboard            sb = new();

  flash_wear_level_remapper_top #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .PAGE_BLOCKS (PAGE_BLOCKS),
    .GROUP_BLOCKS(GROUP_BLOCKS),
    .FLASH_BLOCKS(FLASH_BLOCKS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    cmd_ready = ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid === 1'b1 && cmd_ready) sb.check_cmd(cmd);
    if (rst || (item_valid && item_ready === 1'b1) || (cmd_valid === 1'b1 && cmd_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("flash_wear_level_remapper_top_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic fwlr_pkg::item_t request_item(logic [1:0] op,
                                                   logic [fwlr_pkg::BLK_W-1:0] blk);
    fwlr_pkg::item_t it;
    it               = ITEM_W'({$urandom, $urandom});
    it.operation     = op;
    it.logical_block = blk;
    return it;
  endfunction

  function automatic fwlr_pkg::item_t fill_item(int idx, logic [15:0] value);
    fwlr_pkg::item_t it;
    it            = ITEM_W'({$urandom, $urandom});
    it.operation  = fwlr_pkg::OP_FILL;
    it.fill_index = 5'(idx);
    it.fill_value = value;
    return it;
  endfunction

  function automatic logic [15:0] entry_pick(fill_mode_t mode);
    logic [15:0] v;
    int          r;
    r = $urandom_range(0, 99);
    v = 16'($urandom);
    case (mode)
      FILL_SPARSE: begin
        if (r < 65) v = fwlr_pkg::FREE_ENTRY;
        else if (r < 85) v = 16'(hot_blocks[$urandom_range(0, 3)]);
      end
      FILL_PACKED: begin
        if (r < 50) v = 16'(hot_blocks[$urandom_range(0, 3)]);
        else if (r < 58) v = '0;
        if (v == fwlr_pkg::FREE_ENTRY) v = 16'hFFFE;
      end
      default: begin
        if (r < 30) v = fwlr_pkg::FREE_ENTRY;
        else if (r < 65) v = 16'(hot_blocks[$urandom_range(0, 3)]);
      end
    endcase
    return v;
  endfunction

  function automatic logic [1:0] any_request_op();
    return ($urandom_range(0, 1) == 1) ? fwlr_pkg::OP_WRITE : fwlr_pkg::OP_READ;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(fwlr_pkg::item_t it);
    if (useful_items < ITEM_TARGET / 3) begin
      send_idle = 7;
      recv_idle = 73;
    end else if (useful_items < 2 * ITEM_TARGET / 3) begin
      send_idle = 73;
      recv_idle = 7;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    // never complete a map load while some entry is still unwritten
    if (it.operation == fwlr_pkg::OP_FILL && sb.hold_valid &&
        it.fill_index == 5'(PAGE_BLOCKS - 1) &&
        sb.loaded_entries[PAGE_BLOCKS-2:0] != '1) begin
      for (int i = PAGE_BLOCKS - 2; i >= 0; i--) begin
        if (!sb.loaded_entries[i]) it.fill_index = 5'(i);
      end
    end
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
    if (sb.note_item(it)) useful_items++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_valid = 1'b0;
    while (sb.cmd_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int                         r;
    int                         pick;
    int                         g;
    int                         n;
    int                         last_group;
    fill_mode_t                 mode;
    logic [fwlr_pkg::BLK_W-1:0] blk;
    fwlr_pkg::item_t            it;

    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cmd_ready    = 1'b0;
    useful_items = 0;
    quiet_cycles = 0;
    send_idle    = 7;
    recv_idle    = 73;
    last_group   = 0;
    foreach (hot_blocks[k]) hot_blocks[k] = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_item(fill_item(PAGE_BLOCKS - 1, 16'h1234));
    send_item({OP_NONE, {fwlr_pkg::BLK_W{1'b1}}, 5'h1f, 16'hFFFF});
    send_item(request_item(fwlr_pkg::OP_READ, '0));
    send_item(request_item(fwlr_pkg::OP_WRITE, fwlr_pkg::BLK_W'(FLASH_BLOCKS - 1)));
    send_item(request_item(fwlr_pkg::OP_READ, fwlr_pkg::BLK_W'(FLASH_BLOCKS - 1)));
    send_item(request_item(fwlr_pkg::OP_READ, fwlr_pkg::BLK_W'(GROUP_BLOCKS - 1)));
    drain_results();

    while (useful_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        g = ($urandom_range(0, 1) == 1) ? last_group : $urandom_range(0, GROUPS - 1);
        if (g != last_group || !sb.map_ready) begin
          foreach (hot_blocks[k]) begin
            hot_blocks[k] = fwlr_pkg::BLK_W'(g * GROUP_BLOCKS +
                                             $urandom_range(0, GROUP_BLOCKS - 1));
          end
        end
        last_group = g;
        send_item(request_item(any_request_op(),
                               fwlr_pkg::BLK_W'(g * GROUP_BLOCKS +
                                                $urandom_range(0, GROUP_BLOCKS - 1))));
        if (sb.hold_valid) begin
          mode = fill_mode_t'($urandom_range(0, 2));
          for (int i = 0; i < PAGE_BLOCKS; i++) send_item(fill_item(i, entry_pick(mode)));
        end
        n = $urandom_range(1, 10);
        repeat (n) begin
          if ($urandom_range(0, 1) == 1) blk = hot_blocks[$urandom_range(0, 3)];
          else blk = fwlr_pkg::BLK_W'(g * GROUP_BLOCKS + $urandom_range(0, GROUP_BLOCKS - 1));
          send_item(request_item(any_request_op(), blk));
        end
      end else if (r < 78) begin
        send_item(request_item(any_request_op(),
                               fwlr_pkg::BLK_W'($urandom_range(0, FLASH_BLOCKS - 1))));
        n = $urandom_range(0, PAGE_BLOCKS + 8);
        repeat (n) begin
          if ($urandom_range(0, 99) < 5) begin
            send_item(request_item(any_request_op(),
                                   fwlr_pkg::BLK_W'($urandom_range(0, FLASH_BLOCKS - 1))));
          end else begin
            send_item(fill_item($urandom_range(0, PAGE_BLOCKS - 1), entry_pick(FILL_MIXED)));
          end
        end
      end else if (r < 90) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          pick = $urandom_range(0, 3);
          it   = ITEM_W'({$urandom, $urandom});
          if (pick == 2) it.operation = fwlr_pkg::OP_FILL;
          else if (pick == 3) it.operation = OP_NONE;
          send_item(it);
        end
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) blk = '0;
          else if (pick == 1) blk = fwlr_pkg::BLK_W'(FLASH_BLOCKS - 1);
          else blk = fwlr_pkg::BLK_W'($urandom_range(0, FLASH_BLOCKS - 1));
          send_item(request_item(any_request_op(), blk));
        end
      end
      if ($urandom_range(0, 99) < 8) drain_results();
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (sb.n_fail == 0 && sb.cmd_q.size() == 0) begin
      $display("flash_wear_level_remapper_top_tb OK");
    end else begin
      $display("flash_wear_level_remapper_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fwlr_pkg.sv
hw/rtl/flash_wear_level_remapper_top.sv
tb/flash_wear_level_remapper_top_tb.sv
